// File: sv/pwts_pkg.sv
// shared constants for the perspective world-to-screen block
// no dependencies
package pwts_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int SIZE_W          = 14;
	localparam int NEAR_W          = 31;
	localparam int DATA_W          = 32;
	localparam int PADDR_W         = 4;
	localparam int DIV_STEPS       = 2;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(1024);
	localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(768);
	localparam logic [NEAR_W-1:0] NEAR_RST   = NEAR_W'(6554);

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_NEAR   = 2'd2;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PROJECT = 1'b1;

endpackage

// File: sv/pwts_div_step.sv
// STEPS restoring-division steps: remainder and quotient shift register
// uses pwts_pkg for the quotient width
module pwts_div_step #(
	parameter int W     = 50,
	parameter int STEPS = pwts_pkg::DIV_STEPS
) (
	input  logic [W-1:0]                  d,
	input  logic [W-1:0]                  r_i,
	input  logic [pwts_pkg::DATA_W-1:0]   q_i,
	output logic [W-1:0]                  r_o,
	output logic [pwts_pkg::DATA_W-1:0]   q_o
);

	always_comb begin
		logic [W:0]                 t;
		logic [W-1:0]               r;
		logic [pwts_pkg::DATA_W-1:0] q;
		logic                       ge;
		r = r_i;
		q = q_i;
		for (int k = 0; k < STEPS; k++) begin
			t  = {r, q[pwts_pkg::DATA_W-1]};
			ge = (t >= {1'b0, d});
			r  = ge ? W'(t - {1'b0, d}) : t[W-1:0];
			q  = {q[pwts_pkg::DATA_W-2:0], ge};
		end
		r_o = r;
		q_o = q;
	end

endmodule

// File: sv/perspective_world_to_screen.sv
// perspective world-to-screen top level: matrix, clip sums, pipelined divide
// depends on pwts_pkg and pwts_div_step
// fully pipelined divider, one stage per DIV_STEPS bits, after stages s1 to s4 and divider start
// throughput: one beat per cycle while the result is not stalled, set by the divider
// a stalled result holds the whole pipeline, bubbles included, and stalls the input
// reset: matrix cleared to zero, registers to defaults, all valid bits cleared
module perspective_world_to_screen #(
	parameter int FRAC_BITS = pwts_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pwts_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic [3:0]                      coef_index,
	input  logic signed [31:0]              coef_value,
	input  logic signed [31:0]              pos_x,
	input  logic signed [31:0]              pos_y,
	input  logic signed [31:0]              pos_z,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            visible,
	output logic signed [31:0]              screen_x,
	output logic signed [31:0]              screen_y
);

	localparam int CLIP_W = 66 - FRAC_BITS;
	localparam int FL_W   = 64 - FRAC_BITS;
	localparam int P_W    = CLIP_W + pwts_pkg::SIZE_W;
	localparam int H_W    = P_W - 32 + FRAC_BITS;
	localparam int NDIV   = pwts_pkg::DATA_W / pwts_pkg::DIV_STEPS;

	// configuration
	logic [pwts_pkg::SIZE_W-1:0] width_q, height_q;
	logic [pwts_pkg::NEAR_W-1:0] near_q;
	logic                        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pwts_pkg::WIDTH_RST;
			height_q <= pwts_pkg::HEIGHT_RST;
			near_q   <= pwts_pkg::NEAR_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				pwts_pkg::REG_WIDTH:  width_q  <= pwdata[pwts_pkg::SIZE_W-1:0];
				pwts_pkg::REG_HEIGHT: height_q <= pwdata[pwts_pkg::SIZE_W-1:0];
				pwts_pkg::REG_NEAR:   near_q   <= pwdata[pwts_pkg::NEAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			pwts_pkg::REG_WIDTH:  prdata = 32'(width_q);
			pwts_pkg::REG_HEIGHT: prdata = 32'(height_q);
			pwts_pkg::REG_NEAR:   prdata = 32'(near_q);
			default:              prdata = '0;
		endcase
	end

	// pipeline control
	logic adv, acc;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;
	assign acc      = in_valid && adv;

	// view matrix, column-major
	logic signed [31:0] mat_q [16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) mat_q[i] <= '0;
		end else if (acc && opcode == pwts_pkg::OP_LOAD) begin
			mat_q[coef_index] <= coef_value;
		end
	end

	// s1: floored products and translations
	logic                     vld_s1;
	logic signed [FL_W-1:0]   pr_s1 [3][3];
	logic signed [31:0]       tr_s1 [3];
	logic signed [63:0]       prod  [3][3];
	logic signed [31:0]       pos   [3];

	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;

	// rows 0, 1 and 3 give clip x, y and w
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod[r][c] = pos[c] * mat_q[4*c + (r == 2 ? 3 : r)];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= acc && opcode == pwts_pkg::OP_PROJECT;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) pr_s1[r][c] <= prod[r][c][63:FRAC_BITS];
				tr_s1[r] <= mat_q[12 + (r == 2 ? 3 : r)];
			end
		end
	end

	// s2: clip sums
	logic                     vld_s2;
	logic signed [CLIP_W-1:0] clip_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 3; r++) begin
				clip_s2[r] <= CLIP_W'(tr_s1[r]) + CLIP_W'(pr_s1[r][0])
					+ CLIP_W'(pr_s1[r][1]) + CLIP_W'(pr_s1[r][2]);
			end
		end
	end

	// s3: near test, numerators to sign and magnitude
	logic                     vld_s3, vis_s3, negx_s3, negy_s3;
	logic [CLIP_W-1:0]        magx_s3, magy_s3, d_s3;
	logic signed [CLIP_W-1:0] numx, numy, cw;

	assign cw   = clip_s2[2];
	assign numx = clip_s2[0] + cw;
	assign numy = cw - clip_s2[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s3  <= (cw >= $signed(CLIP_W'(near_q))) && (cw > 0);
			negx_s3 <= numx[CLIP_W-1];
			negy_s3 <= numy[CLIP_W-1];
			magx_s3 <= numx[CLIP_W-1] ? CLIP_W'(-numx) : numx;
			magy_s3 <= numy[CLIP_W-1] ? CLIP_W'(-numy) : numy;
			d_s3    <= {cw[CLIP_W-2:0], 1'b0};
		end
	end

	// s4: scale by viewport size
	logic              vld_s4, vis_s4, negx_s4, negy_s4;
	logic [P_W-1:0]    px_s4, py_s4;
	logic [CLIP_W-1:0] d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s4  <= vis_s3;
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			px_s4   <= P_W'(magx_s3) * P_W'(width_q);
			py_s4   <= P_W'(magy_s3) * P_W'(height_q);
			d_s4    <= d_s3;
		end
	end

	// s5: overflow check on the high part, divider start
	logic [H_W-1:0] hix, hiy;
	logic [63:0]    hix64, hiy64;

	assign hix   = px_s4[P_W-1:32-FRAC_BITS];
	assign hiy   = py_s4[P_W-1:32-FRAC_BITS];
	assign hix64 = 64'(hix);
	assign hiy64 = 64'(hiy);

	logic              vld_sd  [NDIV+1];
	logic              vis_sd  [NDIV+1];
	logic              negx_sd [NDIV+1];
	logic              negy_sd [NDIV+1];
	logic              bigx_sd [NDIV+1];
	logic              bigy_sd [NDIV+1];
	logic [CLIP_W-1:0] d_sd    [NDIV+1];
	logic [CLIP_W-1:0] rx_sd   [NDIV+1];
	logic [CLIP_W-1:0] ry_sd   [NDIV+1];
	logic [31:0]       qx_sd   [NDIV+1];
	logic [31:0]       qy_sd   [NDIV+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sd[0] <= 1'b0;
		else if (adv) vld_sd[0] <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_sd[0]  <= vis_s4;
			negx_sd[0] <= negx_s4;
			negy_sd[0] <= negy_s4;
			bigx_sd[0] <= hix64 >= 64'(d_s4);
			bigy_sd[0] <= hiy64 >= 64'(d_s4);
			d_sd[0]    <= d_s4;
			rx_sd[0]   <= hix64[CLIP_W-1:0];
			ry_sd[0]   <= hiy64[CLIP_W-1:0];
			qx_sd[0]   <= {px_s4[31-FRAC_BITS:0], FRAC_BITS'(0)};
			qy_sd[0]   <= {py_s4[31-FRAC_BITS:0], FRAC_BITS'(0)};
		end
	end

	// divider stages
	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic [CLIP_W-1:0] rx_n, ry_n;
		logic [31:0]       qx_n, qy_n;

		pwts_div_step #(.W(CLIP_W), .STEPS(pwts_pkg::DIV_STEPS)) u_dx (
			.d(d_sd[k]), .r_i(rx_sd[k]), .q_i(qx_sd[k]), .r_o(rx_n), .q_o(qx_n)
		);
		pwts_div_step #(.W(CLIP_W), .STEPS(pwts_pkg::DIV_STEPS)) u_dy (
			.d(d_sd[k]), .r_i(ry_sd[k]), .q_i(qy_sd[k]), .r_o(ry_n), .q_o(qy_n)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sd[k+1] <= 1'b0;
			else if (adv) vld_sd[k+1] <= vld_sd[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				vis_sd[k+1]  <= vis_sd[k];
				negx_sd[k+1] <= negx_sd[k];
				negy_sd[k+1] <= negy_sd[k];
				bigx_sd[k+1] <= bigx_sd[k];
				bigy_sd[k+1] <= bigy_sd[k];
				d_sd[k+1]    <= d_sd[k];
				rx_sd[k+1]   <= rx_n;
				ry_sd[k+1]   <= ry_n;
				qx_sd[k+1]   <= qx_n;
				qy_sd[k+1]   <= qy_n;
			end
		end
	end

	// output stage: saturate, restore sign, blank when not visible
	logic [31:0] limx, limy, satx, saty, qx, qy;
	logic        vld_out_q, vis_out_q;
	logic [31:0] sx_out_q, sy_out_q;

	assign qx   = qx_sd[NDIV];
	assign qy   = qy_sd[NDIV];
	assign limx = negx_sd[NDIV] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign limy = negy_sd[NDIV] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign satx = (bigx_sd[NDIV] || qx > limx) ? limx : qx;
	assign saty = (bigy_sd[NDIV] || qy > limy) ? limy : qy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out_q <= 1'b0;
		else if (adv) vld_out_q <= vld_sd[NDIV];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_out_q <= vis_sd[NDIV];
			sx_out_q  <= !vis_sd[NDIV] ? '0 : (negx_sd[NDIV] ? 32'(-satx) : satx);
			sy_out_q  <= !vis_sd[NDIV] ? '0 : (negy_sd[NDIV] ? 32'(-saty) : saty);
		end
	end

	assign out_valid = vld_out_q;
	assign visible   = vis_out_q;
	assign screen_x  = sx_out_q;
	assign screen_y  = sy_out_q;

`ifndef SYNTHESIS
	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !visible) |-> (screen_x == 0 && screen_y == 0))
		else $error("hidden point with non-zero screen position");
	a_vis_w: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && vis_s3) |-> (d_s3 != 0))
		else $error("visible point with zero divisor");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(vld_s1) && $stable(vld_sd[0])))
		else $error("pipeline moved while result stalled");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && opcode == pwts_pkg::OP_LOAD) |=> !vld_s1)
		else $error("matrix load produced a result");
`endif

endmodule
